[rtl/core/repulsive_force_accumulator_macros.svh]
// ----------------------------------------------------------------------------
// Repulsive force accumulator assertion macros
// Concurrent assertion wrappers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef REPULSIVE_FORCE_ACCUMULATOR_MACROS_SVH
`define REPULSIVE_FORCE_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define RFA_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define RFA_ASSERT(lbl, prop, msg) `RFA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define RFA_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define RFA_ASSERT(lbl, prop, msg)
`endif

`endif

[rtl/core/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// Repulsive force accumulator package
// Shared types, register indexes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int NUM_REGS = 8;

  localparam logic [3:0] REG_WIN_MIN_X = 4'd0;
  localparam logic [3:0] REG_WIN_MIN_Y = 4'd1;
  localparam logic [3:0] REG_WIN_MIN_Z = 4'd2;
  localparam logic [3:0] REG_WIN_MAX_X = 4'd3;
  localparam logic [3:0] REG_WIN_MAX_Y = 4'd4;
  localparam logic [3:0] REG_WIN_MAX_Z = 4'd5;
  localparam logic [3:0] REG_INFL_DIST = 4'd6;
  localparam logic [3:0] REG_GAIN      = 4'd7;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    STP_SQX  = 4'd0,
    STP_SQY  = 4'd1,
    STP_SQM  = 4'd2,
    STP_SQRT = 4'd3,
    STP_INVD = 4'd4,
    STP_INVM = 4'd5,
    STP_TT   = 4'd6,
    STP_ETA  = 4'd7,
    STP_UX   = 4'd8,
    STP_MX   = 4'd9,
    STP_UY   = 4'd10,
    STP_MY   = 4'd11
  } step_t;

  typedef struct packed {
    logic  load_in;
    logic  eval_win;
    logic  start;
    logic  capture;
    logic  emit;
    step_t step;
  } ctl_cmd_t;

  typedef struct packed {
    logic win_pass;
    logic range_bad;
    logic iter_busy;
    logic iter_done;
    logic last;
    logic out_free;
  } dp_sts_t;

  function automatic op_t step_op(input step_t s);
    op_t o;
    unique case (s)
      STP_SQRT:                         o = OP_SQRT;
      STP_INVD, STP_INVM, STP_UX, STP_UY: o = OP_DIV;
      default:                          o = OP_MUL;
    endcase
    return o;
  endfunction

endpackage

[rtl/core/rfa_iter.sv]
// ----------------------------------------------------------------------------
// Repulsive force accumulator sequential arithmetic unit
// Shared multi-cycle multiply (64x16 per cycle), restoring divide and root.
// ----------------------------------------------------------------------------
module rfa_iter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  rfa_pkg::op_t     op,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  input  logic [5:0]       k,
  output logic             busy,
  output logic             done,
  output logic [63:0]      res_lo,
  output logic             res_ovf
);
  import rfa_pkg::*;

  op_t          op_r;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [5:0]   k_r, k_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  ra_r, ra_nxt;
  logic [63:0]  rb_r, rb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [32:0]  rem_r, rem_nxt;
  op_t          op_nxt;

  logic [79:0]  pp;
  logic [33:0]  trial_d;
  logic         div_ge;
  logic [63:0]  sq_t;
  logic         sq_ge;
  logic         last_step;
  logic [5:0]   div_sh;

  always_comb begin
    pp      = 80'(ra_r) * 80'(rb_r[15:0]);
    trial_d = {rem_r, ra_r[63]};
    div_ge  = trial_d >= {2'b00, rb_r[31:0]};
    sq_t    = acc_r[63:0] + rb_r;
    sq_ge   = ra_r >= sq_t;
    div_sh  = 6'(7'd64 - 7'(k));
    op_nxt  = op_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ra_nxt  = ra_r;
    rb_nxt  = rb_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    last_step = 1'b0;
    if (start) begin
      op_nxt   = op;
      k_nxt    = k;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      ra_nxt   = a;
      rb_nxt   = b;
      unique case (op)
        OP_DIV: begin
          rem_nxt = 33'(a >> k);
          ra_nxt  = a << div_sh;
        end
        OP_SQRT: rb_nxt = 64'(1) << 62;
        default: ;
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 6'd1;
      unique case (op_r)
        OP_MUL: begin
          acc_nxt   = acc_r + (128'(pp) << {cnt_r[1:0], 4'b0000});
          rb_nxt    = rb_r >> 16;
          last_step = cnt_r == 6'd3;
        end
        OP_DIV: begin
          rem_nxt   = div_ge ? 33'(trial_d - {2'b00, rb_r[31:0]}) : trial_d[32:0];
          ra_nxt    = ra_r << 1;
          acc_nxt   = {64'd0, acc_r[62:0], div_ge};
          last_step = cnt_r == 6'(k_r - 6'd1);
        end
        OP_SQRT: begin
          if (sq_ge) begin
            ra_nxt  = ra_r - sq_t;
            acc_nxt = {64'd0, (acc_r[63:0] >> 1) + rb_r};
          end else begin
            acc_nxt = {64'd0, acc_r[63:0] >> 1};
          end
          rb_nxt    = rb_r >> 2;
          last_step = cnt_r == 6'd31;
        end
        default: last_step = 1'b1;
      endcase
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    ra_r  <= ra_nxt;
    rb_r  <= rb_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign res_lo  = acc_r[63:0];
  assign res_ovf = |acc_r[127:63];

endmodule

[rtl/core/rfa_dp.sv]
// ----------------------------------------------------------------------------
// Repulsive force accumulator datapath
// Config registers, item registers, window test, force sums and result word.
// ----------------------------------------------------------------------------
module rfa_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rfa_pkg::ctl_cmd_t  cmd,
  output rfa_pkg::dp_sts_t   sts,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [31:0] in_robot_z,
  input  logic signed [31:0] in_obs_x,
  input  logic signed [31:0] in_obs_y,
  input  logic signed [31:0] in_obs_z,
  input  logic [30:0]        in_major_len,
  input  logic [30:0]        in_minor_len,
  input  logic               in_obs_present,
  input  logic               in_last_obstacle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic               out_avoiding
);
  import rfa_pkg::*;

  localparam int          ONE     = 1 << FRAC_BITS;
  localparam int          Z_MARG  = ((5 << FRAC_BITS) + 50) / 100;
  localparam int          U_W     = FRAC_BITS + 1;
  localparam logic [63:0] ONE_SQ  = 64'(1) << (2 * FRAC_BITS);
  localparam logic [63:0] CAP     = (64'(1) << (63 - FRAC_BITS)) - 64'd1;
  localparam logic [5:0]  K_INV   = 6'(2 * FRAC_BITS + 1);
  localparam logic [5:0]  K_UNIT  = 6'(FRAC_BITS + 1);

  logic signed [31:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;
  logic [30:0]        dmax_r;
  logic [31:0]        gain_r;

  logic signed [31:0] rx_r, ry_r, rz_r, ox_r, oy_r, oz_r;
  logic [30:0]        maj_r, mnr_r;
  logic               pres_r, last_r;
  logic [30:0]        adx_r, ady_r;
  logic               dxpos_r, dypos_r;
  logic [63:0]        w_r, d2_r;
  logic [31:0]        d_r;
  logic [U_W-1:0]     u_r;
  logic signed [31:0] sum_x_r, sum_y_r;
  logic signed [31:0] fx_r, fy_r;
  logic               avoid_r, out_valid_r;

  logic signed [35:0] rx_e, ry_e, rz_e, ox_e, oy_e, oz_e, maj_e, mnr_e, dmax_e;
  logic signed [35:0] dx, dy, adx, ady;
  logic               win_fail, win_pass;

  logic         it_busy, it_done, it_ovf;
  logic [63:0]  it_res, it_a, it_b, mulq;
  logic [5:0]   it_k;
  logic         out_free;

  function automatic logic signed [31:0] sat_acc(input logic signed [31:0] sum,
                                                 input logic [63:0] mag,
                                                 input logic neg);
    logic [32:0]        c;
    logic signed [35:0] t;
    c = (mag > 64'h1_0000_0000) ? 33'h1_0000_0000 : mag[32:0];
    t = neg ? 36'(sum) - $signed({3'b000, c}) : 36'(sum) + $signed({3'b000, c});
    if (t > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -36'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return t[31:0];
  endfunction

  always_comb begin
    rx_e   = 36'(rx_r);
    ry_e   = 36'(ry_r);
    rz_e   = 36'(rz_r);
    ox_e   = 36'(ox_r);
    oy_e   = 36'(oy_r);
    oz_e   = 36'(oz_r);
    maj_e  = $signed({5'b00000, maj_r});
    mnr_e  = $signed({5'b00000, mnr_r});
    dmax_e = $signed({5'b00000, dmax_r});
    win_fail = ((ox_e <<< 1) + maj_e < ((rx_e + 36'(min_x_r)) <<< 1)) ||
               ((ox_e <<< 1) - maj_e > ((rx_e + 36'(max_x_r)) <<< 1)) ||
               ((oy_e <<< 1) + mnr_e < ((ry_e + 36'(min_y_r)) <<< 1)) ||
               ((oy_e <<< 1) - mnr_e > ((ry_e + 36'(max_y_r)) <<< 1)) ||
               (oz_e + 36'(Z_MARG) < rz_e + 36'(min_z_r)) ||
               (oz_e - 36'(Z_MARG) > rz_e + 36'(max_z_r));
    dx  = ox_e - rx_e;
    dy  = oy_e - ry_e;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    win_pass = pres_r && !win_fail && (dmax_r != '0) && (adx <= dmax_e) && (ady <= dmax_e);
  end

  always_comb begin
    it_a = '0;
    it_b = '0;
    it_k = '0;
    case (cmd.step)
      STP_SQX:  begin it_a = 64'(adx_r);  it_b = 64'(adx_r); end
      STP_SQY:  begin it_a = 64'(ady_r);  it_b = 64'(ady_r); end
      STP_SQM:  begin it_a = 64'(dmax_r); it_b = 64'(dmax_r); end
      STP_SQRT: it_a = d2_r;
      STP_INVD: begin it_a = ONE_SQ; it_b = 64'(d_r);    it_k = K_INV; end
      STP_INVM: begin it_a = ONE_SQ; it_b = 64'(dmax_r); it_k = K_INV; end
      STP_TT:   begin it_a = w_r; it_b = w_r; end
      STP_ETA:  begin it_a = w_r; it_b = 64'(gain_r); end
      STP_UX:   begin it_a = 64'(adx_r) << FRAC_BITS; it_b = 64'(d_r); it_k = K_UNIT; end
      STP_UY:   begin it_a = 64'(ady_r) << FRAC_BITS; it_b = 64'(d_r); it_k = K_UNIT; end
      STP_MX, STP_MY: begin it_a = w_r; it_b = 64'(u_r); end
      default: ;
    endcase
  end

  rfa_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start),
    .op      (step_op(cmd.step)),
    .a       (it_a),
    .b       (it_b),
    .k       (it_k),
    .busy    (it_busy),
    .done    (it_done),
    .res_lo  (it_res),
    .res_ovf (it_ovf)
  );

  assign mulq     = it_ovf ? CAP : (it_res >> FRAC_BITS);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= 32'(-5 * ONE);
      min_y_r <= 32'(-5 * ONE);
      min_z_r <= 32'(-ONE);
      max_x_r <= 32'(5 * ONE);
      max_y_r <= 32'(5 * ONE);
      max_z_r <= 32'(ONE);
      dmax_r  <= 31'(2 * ONE);
      gain_r  <= 32'(ONE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIN_MIN_X: min_x_r <= cfg_data;
        REG_WIN_MIN_Y: min_y_r <= cfg_data;
        REG_WIN_MIN_Z: min_z_r <= cfg_data;
        REG_WIN_MAX_X: max_x_r <= cfg_data;
        REG_WIN_MAX_Y: max_y_r <= cfg_data;
        REG_WIN_MAX_Z: max_z_r <= cfg_data;
        REG_INFL_DIST: dmax_r  <= cfg_data[30:0];
        REG_GAIN:      gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rx_r   <= in_robot_x;
      ry_r   <= in_robot_y;
      rz_r   <= in_robot_z;
      ox_r   <= in_obs_x;
      oy_r   <= in_obs_y;
      oz_r   <= in_obs_z;
      maj_r  <= in_major_len;
      mnr_r  <= in_minor_len;
      pres_r <= in_obs_present;
      last_r <= in_last_obstacle;
    end
    if (cmd.eval_win) begin
      adx_r   <= adx[30:0];
      ady_r   <= ady[30:0];
      dxpos_r <= dx > 0;
      dypos_r <= dy > 0;
    end
    if (cmd.capture) begin
      case (cmd.step)
        STP_SQX:  w_r  <= it_res;
        STP_SQY:  d2_r <= w_r + it_res;
        STP_SQRT: d_r  <= it_res[31:0];
        STP_INVD: w_r  <= it_res;
        STP_INVM: w_r  <= w_r - it_res;
        STP_TT:   w_r  <= mulq;
        STP_ETA:  w_r  <= mulq >> 1;
        STP_UX, STP_UY: u_r <= it_res[U_W-1:0];
        default: ;
      endcase
    end
    if (cmd.emit) begin
      fx_r    <= sum_x_r;
      fy_r    <= sum_y_r;
      avoid_r <= (sum_x_r != '0) || (sum_y_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
      end else if (cmd.capture && cmd.step == STP_MX) begin
        sum_x_r <= sat_acc(sum_x_r, it_res >> FRAC_BITS, dxpos_r);
      end else if (cmd.capture && cmd.step == STP_MY) begin
        sum_y_r <= sat_acc(sum_y_r, it_res >> FRAC_BITS, dypos_r);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.win_pass  = win_pass;
    sts.range_bad = (d2_r == '0) || (d2_r > it_res);
    sts.iter_busy = it_busy;
    sts.iter_done = it_done;
    sts.last      = last_r;
    sts.out_free  = out_free;
  end

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_force_x  = fx_r;
  assign out_force_y  = fy_r;
  assign out_avoiding = avoid_r;

endmodule

[rtl/core/rfa_ctrl.sv]
// ----------------------------------------------------------------------------
// Repulsive force accumulator controller
// One-hot sequencer stepping the datapath through one obstacle word.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfa_pkg::dp_sts_t  sts,
  output rfa_pkg::ctl_cmd_t cmd
);
  import rfa_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_WIN  = 16'h0002,
    S_SQX  = 16'h0004,
    S_SQY  = 16'h0008,
    S_SQM  = 16'h0010,
    S_SQRT = 16'h0020,
    S_INVD = 16'h0040,
    S_INVM = 16'h0080,
    S_TT   = 16'h0100,
    S_ETA  = 16'h0200,
    S_UX   = 16'h0400,
    S_MX   = 16'h0800,
    S_UY   = 16'h1000,
    S_MY   = 16'h2000,
    S_FIN  = 16'h4000,
    S_EMIT = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;

  always_comb begin
    state_nxt    = state_r;
    go_nxt       = 1'b0;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.eval_win = 1'b0;
    cmd.start    = 1'b0;
    cmd.capture  = 1'b0;
    cmd.emit     = 1'b0;
    cmd.step     = STP_SQX;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_WIN;
        end
      end
      S_WIN: begin
        cmd.eval_win = 1'b1;
        if (sts.win_pass) begin
          state_nxt = S_SQX;
          go_nxt    = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = sts.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        cmd.start   = go_r;
        cmd.capture = sts.iter_done;
        unique case (state_r)
          S_SQX:   cmd.step = STP_SQX;
          S_SQY:   cmd.step = STP_SQY;
          S_SQM:   cmd.step = STP_SQM;
          S_SQRT:  cmd.step = STP_SQRT;
          S_INVD:  cmd.step = STP_INVD;
          S_INVM:  cmd.step = STP_INVM;
          S_TT:    cmd.step = STP_TT;
          S_ETA:   cmd.step = STP_ETA;
          S_UX:    cmd.step = STP_UX;
          S_MX:    cmd.step = STP_MX;
          S_UY:    cmd.step = STP_UY;
          default: cmd.step = STP_MY;
        endcase
        if (sts.iter_done) begin
          go_nxt = 1'b1;
          unique case (state_r)
            S_SQX:   state_nxt = S_SQY;
            S_SQY:   state_nxt = S_SQM;
            S_SQM: begin
              state_nxt = sts.range_bad ? S_FIN : S_SQRT;
              go_nxt    = !sts.range_bad;
            end
            S_SQRT:  state_nxt = S_INVD;
            S_INVD:  state_nxt = S_INVM;
            S_INVM:  state_nxt = S_TT;
            S_TT:    state_nxt = S_ETA;
            S_ETA:   state_nxt = S_UX;
            S_UX:    state_nxt = S_MX;
            S_MX:    state_nxt = S_UY;
            S_UY:    state_nxt = S_MY;
            default: begin
              state_nxt = S_FIN;
              go_nxt    = 1'b0;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

endmodule

[rtl/core/repulsive_force_accumulator.sv]
// ----------------------------------------------------------------------------
// Repulsive force accumulator
// Potential-field repulsive force summed over a list of obstacle ellipses.
// ----------------------------------------------------------------------------
// One obstacle word is taken at a time, and the next word is accepted once the
// current one is done. A word whose obstacle is absent, falls outside the
// window or lies beyond the influence distance on either axis goes from the
// window test straight to the finish state. One that fails the squared-distance
// range test, or sits at zero distance, stops after the squaring steps. One
// that contributes runs every operation, one after another, on the single
// shared sequential unit: seven 4-step multiplies, a 32-step square root and
// four one-bit-per-cycle divisions (two of 2*FRAC_BITS+1 steps, two of
// FRAC_BITS+1 steps). Each operation is started, runs its steps and then
// signals done. For the word marked last_obstacle, an emit state then loads
// the result register and clears the sums. The emit waits while an earlier
// result is still held. The next word is accepted while the new result waits.
module repulsive_force_accumulator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [31:0] in_robot_z,
  input  logic signed [31:0] in_obs_x,
  input  logic signed [31:0] in_obs_y,
  input  logic signed [31:0] in_obs_z,
  input  logic [30:0]        in_major_len,
  input  logic [30:0]        in_minor_len,
  input  logic               in_obs_present,
  input  logic               in_last_obstacle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic               out_avoiding,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import rfa_pkg::*;
  `include "repulsive_force_accumulator_macros.svh"

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfa_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_robot_x       (in_robot_x),
    .in_robot_y       (in_robot_y),
    .in_robot_z       (in_robot_z),
    .in_obs_x         (in_obs_x),
    .in_obs_y         (in_obs_y),
    .in_obs_z         (in_obs_z),
    .in_major_len     (in_major_len),
    .in_minor_len     (in_minor_len),
    .in_obs_present   (in_obs_present),
    .in_last_obstacle (in_last_obstacle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y),
    .out_avoiding     (out_avoiding)
  );

  `RFA_ASSERT(a_start_idle, cmd.start |-> !sts.iter_busy, "unit started while busy")
  `RFA_ASSERT(a_emit_valid, cmd.emit |=> out_valid, "emitted word not presented")
  `RFA_ASSERT(a_valid_src, $rose(out_valid) |-> $past(cmd.emit), "result word without emit")
  `RFA_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready, "second word taken mid-item")

endmodule
